/* rtl/wsts_pkg.sv */
package wsts_pkg;

    // Fixed sizes of the transaction fields.
    localparam int MAX_WORKERS = 8;
    localparam int WID_W       = 3;
    localparam int NW_W        = 4;
    localparam int TASK_W      = 16;
    localparam int PEND_W      = 8;
    localparam int ACT_W       = 4;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;
    localparam logic [ACT_W-1:0]  ACT_MAX  = '1;

    typedef enum logic [1:0] {
        REQ_SUBMIT   = 2'd0,
        REQ_FETCH    = 2'd1,
        REQ_COMPLETE = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ERR   = 2'd3
    } t_status;

    typedef struct packed {
        t_req               req_type;
        logic [TASK_W-1:0]  task_id;
        logic [WID_W-1:0]   worker_id;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic               task_found;
        logic [TASK_W-1:0]  task_out;
        logic [WID_W-1:0]   source_queue;
        logic               was_stolen;
        logic               pool_idle;
    } t_out_item;

endpackage

/* rtl/work_stealing_task_scheduler.sv */
// Work-stealing task dispatcher with one deque of task identifiers per worker.
//
// Input channel (i_in_valid / o_in_stall / i_in): one transaction is a submit,
// a worker fetch or a worker completion. Output channel (o_out_valid /
// i_out_stall / o_out): exactly one result transaction per request, carrying
// the status, the fetched task if any, its source deque and the idle flag. The
// worker count resets to the full worker count; the user writes it through
// i_cfg_wr_en / i_cfg_wr_data only while the block is idle (not enforced).
//
// In the accept cycle the victim deque is chosen by a rotated priority search
// over the non-empty flags and any read or write of the deque memory is issued.
// In the response state the registered read data is merged into the output
// register. No new request is accepted until that is done, as the deque memory
// read is registered.
// Reset (synchronous, active low) empties every deque and clears the round
// robin pointer and both counters; the deque memory itself is not cleared.
// When the receiver stalls, the result waits in the output register while one
// more request is accepted and processed; that request then holds in the
// response state until the output register is free.
module work_stealing_task_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [3:0]            i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  wsts_pkg::t_in_item    i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output wsts_pkg::t_out_item   o_out
);
    import wsts_pkg::*;

    localparam int QW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int AW        = WID_W + QW;
    localparam int MEM_DEPTH = MAX_WORKERS * (2 ** QW);

    localparam logic [QW-1:0] SLOT_LAST = QW'(QUEUE_DEPTH - 1);
    localparam logic [QW:0]   DEPTH_EXT = (QW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] CNT_FULL  = CW'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    t_state r_state, n_state;

    // Deque bookkeeping and pool counters.
    logic [QW-1:0]     r_front [MAX_WORKERS];
    logic [CW-1:0]     r_count [MAX_WORKERS];
    logic [WID_W-1:0]  r_rr;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic [ACT_W-1:0]  r_act, n_act;
    logic [NW_W-1:0]   r_num_workers;

    // Deque storage: at most one write or one read per request, read data registered.
    logic [TASK_W-1:0] r_mem [MEM_DEPTH];
    logic [TASK_W-1:0] r_rdata;

    t_out_item r_res, n_res;
    t_out_item r_out, out_load;
    logic      r_out_valid;

    logic              in_acc, out_load_en;
    logic [NW_W-1:0]   nw;
    logic              w_ok;
    logic [WID_W-1:0]  q_sub, rr_next;
    logic              own_hit, steal_hit;
    logic [WID_W-1:0]  steal_q, sel_q;
    logic [NW_W-1:0]   scan_idx;
    logic [QW-1:0]     sel_front, push_slot, pop_next, back_slot;
    logic [CW-1:0]     sel_cnt;
    logic [QW:0]       back_sum;
    logic              do_push, do_pop, do_steal, do_cmpl;
    logic [AW-1:0]     mem_addr;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Register values out of range are clamped into 1..MAX_WORKERS.
    always_comb begin
        if (r_num_workers == '0) begin
            nw = NW_W'(1);
        end else if (r_num_workers > NW_W'(MAX_WORKERS)) begin
            nw = NW_W'(MAX_WORKERS);
        end else begin
            nw = r_num_workers;
        end
    end

    assign w_ok = (NW_W'(i_in.worker_id) < nw);

    // A stale round robin pointer falls back to deque 0.
    assign q_sub   = (NW_W'(r_rr) < nw) ? r_rr : '0;
    assign rr_next = ((NW_W'(q_sub) + NW_W'(1)) >= nw) ? '0 : q_sub + WID_W'(1);

    assign own_hit = (r_count[i_in.worker_id] != '0);

    // Victim search: first non-empty deque after the requester, circularly.
    always_comb begin
        steal_hit = 1'b0;
        steal_q   = '0;
        scan_idx  = '0;
        for (int off = 1; off < MAX_WORKERS; off++) begin
            scan_idx = NW_W'(i_in.worker_id) + NW_W'(off);
            if (scan_idx >= nw) begin
                scan_idx = scan_idx - nw;
            end
            if (!steal_hit && (NW_W'(off) < nw) &&
                (r_count[scan_idx[WID_W-1:0]] != '0)) begin
                steal_hit = 1'b1;
                steal_q   = scan_idx[WID_W-1:0];
            end
        end
    end

    assign sel_q     = (i_in.req_type == REQ_SUBMIT) ? q_sub :
                       (own_hit ? i_in.worker_id : steal_q);
    assign sel_front = r_front[sel_q];
    assign sel_cnt   = r_count[sel_q];

    assign push_slot = (sel_front == '0) ? SLOT_LAST : sel_front - QW'(1);
    assign pop_next  = (sel_front == SLOT_LAST) ? '0 : sel_front + QW'(1);
    assign back_sum  = {1'b0, sel_front} + (QW + 1)'(sel_cnt) - (QW + 1)'(1);
    assign back_slot = (back_sum >= DEPTH_EXT) ? QW'(back_sum - DEPTH_EXT)
                                               : back_sum[QW-1:0];

    // Decode of the request and the result fields known in the accept cycle.
    always_comb begin
        n_res    = '0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        do_steal = 1'b0;
        do_cmpl  = 1'b0;
        unique case (i_in.req_type)
            REQ_SUBMIT: begin
                n_res.source_queue = q_sub;
                if (sel_cnt >= CNT_FULL) begin
                    n_res.status = ST_FULL;
                end else begin
                    do_push = 1'b1;
                end
            end
            REQ_FETCH: begin
                if (!w_ok) begin
                    n_res.status = ST_ERR;
                end else if (own_hit) begin
                    do_pop = 1'b1;
                end else if (steal_hit) begin
                    do_steal = 1'b1;
                end else begin
                    n_res.status = ST_EMPTY;
                end
                if (w_ok && (own_hit || steal_hit)) begin
                    n_res.task_found   = 1'b1;
                    n_res.source_queue = sel_q;
                    n_res.was_stolen   = !own_hit;
                end
            end
            REQ_COMPLETE: begin
                if (!w_ok) begin
                    n_res.status = ST_ERR;
                end else begin
                    do_cmpl = 1'b1;
                    if ((r_pend == '0) || (r_act == '0)) begin
                        n_res.status = ST_ERR;
                    end
                end
            end
            default: begin
                n_res.status = ST_ERR;
            end
        endcase

        n_pend = r_pend;
        if (do_push && (r_pend != PEND_MAX)) begin
            n_pend = r_pend + PEND_W'(1);
        end else if (do_cmpl && (r_pend != '0)) begin
            n_pend = r_pend - PEND_W'(1);
        end

        n_act = r_act;
        if ((do_pop || do_steal) && (r_act != ACT_MAX)) begin
            n_act = r_act + ACT_W'(1);
        end else if (do_cmpl && (r_act != '0)) begin
            n_act = r_act - ACT_W'(1);
        end

        n_res.pool_idle = (n_pend == '0) && (n_act == '0);
    end

    assign mem_addr = {sel_q, do_push ? push_slot : (do_steal ? back_slot : sel_front)};

    // Pushes and pops never overlap: each request touches the memory at most once,
    // and the next request is accepted only after the read data is captured.
    always_ff @(posedge i_clk) begin
        if (in_acc && do_push) begin
            r_mem[mem_addr] <= i_in.task_id;
        end
        if (in_acc && (do_pop || do_steal)) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WORKERS; i++) begin
                r_front[i] <= '0;
                r_count[i] <= '0;
            end
            r_rr   <= '0;
            r_pend <= '0;
            r_act  <= '0;
        end else if (in_acc) begin
            if (i_in.req_type == REQ_SUBMIT) begin
                r_rr <= rr_next;
            end
            if (do_push) begin
                r_front[sel_q] <= push_slot;
                r_count[sel_q] <= sel_cnt + CW'(1);
            end else if (do_pop) begin
                r_front[sel_q] <= pop_next;
                r_count[sel_q] <= sel_cnt - CW'(1);
            end else if (do_steal) begin
                r_count[sel_q] <= sel_cnt - CW'(1);
            end
            r_pend <= n_pend;
            r_act  <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_workers <= NW_W'(MAX_WORKERS);
        end else if (i_cfg_wr_en) begin
            r_num_workers <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    // Sequencer: accept, then wait for the output register to take the result.
    assign out_load_en = (r_state == S_RESP) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_load_en) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        out_load          = r_res;
        out_load.task_out = r_res.task_found ? r_rdata : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load_en) begin
            r_out <= out_load;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // An accepted request always moves the sequencer to its response state.
    a_acc_to_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_RESP))
        else $error("accepted request did not enter the response cycle");

    // A returned task is always reported with an ok status.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.task_found) |-> (o_out.status == ST_OK))
        else $error("task returned with a non-ok status");

    // A stolen task is a found task.
    a_stolen_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.was_stolen) |-> o_out.task_found)
        else $error("steal flagged without a task");

    // The result register is loaded only when it is free or being drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out))
        else $error("pending result overwritten");

endmodule
